### rtl/stme_pkg.sv
// ----------------------------------------------------------------------------
// stme_pkg
// shared constants and types of the minimum-eigenvalue corner response block
// ----------------------------------------------------------------------------
package stme_pkg;

  // default sizes handed to the top level
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int GRAD_BITS_DEF  = 12;

  // fixed field widths of the result beat and the config port
  localparam int RESP_W     = 27;
  localparam int ROW_OUT_W  = 12;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_W      = 13;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_ADDR_W = 1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // reset values of the frame size registers
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // position and framing of one queued result
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } stme_tag_t;

endpackage

### rtl/stme_ram.sv
// ----------------------------------------------------------------------------
// stme_ram
// generic single write port ram with one registered read port, read-first
// ----------------------------------------------------------------------------
module stme_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/stme_front.sv
// ----------------------------------------------------------------------------
// stme_front
// takes gradient beats, keeps two line buffers, builds the 3x3 window sums
// and queues one job per result
// ----------------------------------------------------------------------------
module stme_front #(
  parameter int MAX_WIDTH  = stme_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = stme_pkg::MAX_HEIGHT_DEF,
  parameter int GRAD_BITS  = stme_pkg::GRAD_BITS_DEF,
  parameter int TW         = 2 * GRAD_BITS + 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stme_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [stme_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [GRAD_BITS-1:0]         grad_x_i,
  input  logic signed [GRAD_BITS-1:0]         grad_y_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic [2:0][TW-1:0]                  job_sum_o,
  output stme_pkg::stme_tag_t                 job_tag_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int PW     = 2 * GRAD_BITS;
  localparam int ROW_OW = stme_pkg::ROW_OUT_W;
  localparam int COL_OW = stme_pkg::COL_OUT_W;
  localparam int WID_RST = (stme_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : stme_pkg::FRAME_WIDTH_RST;
  localparam int HGT_RST = (stme_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : stme_pkg::FRAME_HEIGHT_RST;

  typedef enum logic [2:0] {
    S_IDLE, S_MULX, S_MULA, S_MULB, S_SUM, S_PUSH
  } state_e;

  state_e                  state_q;
  logic [WID_W-1:0]        width_q;
  logic [HGT_W-1:0]        height_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [3:0]              mask_q;
  logic [GRAD_BITS-1:0]    gx_q, gy_q;
  logic [2:0][TW-1:0]      cx_q, ca_q, cb_q, u_q, l_q;
  logic [2:0][TW-1:0]      up1_q, up2_q, lp1_q, lp2_q;

  logic [WID_W-1:0]        wsat;
  logic [HGT_W-1:0]        hsat;
  logic [stme_pkg::CFG_WID_W-1:0] wval;
  logic                    accept;
  logic [PW-1:0]           rd0, rd1, rd_cur, rd_oth;
  logic signed [GRAD_BITS-1:0] mx, my;
  logic signed [PW-1:0]    pxx, pyy, pxy;
  logic [2:0][TW-1:0]      prod, u_d, l_d, win;
  logic                    c_ge1, r_ge1, c_edge, r_last, r_is1, c_is1, f_end;
  logic [3:0]              mask_d, pick;
  logic [31:0]             row_sel, col_sel;

  function automatic logic [2:0][TW-1:0] add3(input logic [2:0][TW-1:0] a,
                                               input logic [2:0][TW-1:0] b,
                                               input logic [2:0][TW-1:0] c);
    logic [2:0][TW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s[k] = a[k] + b[k] + c[k];
    end
    return s;
  endfunction

  // saturate config writes to the legal frame range
  assign wval = cfg_wdata_i[stme_pkg::CFG_WID_W-1:0];
  always_comb begin
    if (32'(wval) < 32'd2) begin
      wsat = WID_W'(2);
    end else if (32'(wval) > 32'(MAX_WIDTH)) begin
      wsat = WID_W'(MAX_WIDTH);
    end else begin
      wsat = WID_W'(wval);
    end
    if (32'(cfg_wdata_i) < 32'd2) begin
      hsat = HGT_W'(2);
    end else if (32'(cfg_wdata_i) > 32'(MAX_HEIGHT)) begin
      hsat = HGT_W'(MAX_HEIGHT);
    end else begin
      hsat = HGT_W'(cfg_wdata_i);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // line buffers: bank row%2 holds row r-2, the other bank row r-1
  stme_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (accept && !row_q[0]),
    .waddr_i (col_q),
    .wdata_i ({grad_y_i, grad_x_i}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd0)
  );

  stme_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (accept && row_q[0]),
    .waddr_i (col_q),
    .wdata_i ({grad_y_i, grad_x_i}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd1)
  );

  assign rd_cur = row_q[0] ? rd1 : rd0;
  assign rd_oth = row_q[0] ? rd0 : rd1;

  // one set of three products per cycle
  always_comb begin
    case (state_q)
      S_MULA: begin
        mx = $signed(rd_cur[GRAD_BITS-1:0]);
        my = $signed(rd_cur[PW-1:GRAD_BITS]);
      end
      S_MULB: begin
        mx = $signed(rd_oth[GRAD_BITS-1:0]);
        my = $signed(rd_oth[PW-1:GRAD_BITS]);
      end
      default: begin
        mx = $signed(gx_q);
        my = $signed(gy_q);
      end
    endcase
    pxx = mx * mx;
    pyy = my * my;
    pxy = mx * my;
    prod[0] = TW'(pxx);
    prod[1] = TW'(pyy);
    prod[2] = TW'(pxy);
  end

  assign r_ge1  = (row_q != '0);
  assign c_ge1  = (col_q != '0);
  assign r_is1  = (32'(row_q) == 32'd1);
  assign c_is1  = (32'(col_q) == 32'd1);
  assign c_edge = (32'(col_q) + 32'd1 >= 32'(width_q));
  assign r_last = (32'(row_q) + 32'd1 >= 32'(height_q));
  assign f_end  = c_edge && r_last;

  // column sums: upper output row and, on the last row, the bottom row
  assign u_d = add3(r_is1 ? cx_q : ca_q, cb_q, cx_q);
  assign l_d = add3(cb_q, cx_q, cb_q);
  assign mask_d = {r_last && c_ge1 && c_edge, r_last && c_ge1,
                   r_ge1 && c_ge1 && c_edge, r_ge1 && c_ge1};

  // lowest pending job goes first
  assign pick = mask_q & (~mask_q + 4'd1);

  always_comb begin
    win     = add3(up1_q, u_q, up1_q);
    row_sel = 32'(row_q) - 32'd1;
    col_sel = 32'(col_q);
    case (pick)
      4'b0001: begin
        win     = add3(c_is1 ? u_q : up2_q, up1_q, u_q);
        col_sel = 32'(col_q) - 32'd1;
      end
      4'b0010: begin
        win = add3(up1_q, u_q, up1_q);
      end
      4'b0100: begin
        win     = add3(c_is1 ? l_q : lp2_q, lp1_q, l_q);
        row_sel = 32'(row_q);
        col_sel = 32'(col_q) - 32'd1;
      end
      4'b1000: begin
        win     = add3(lp1_q, l_q, lp1_q);
        row_sel = 32'(row_q);
      end
      default: begin
        win = add3(up1_q, u_q, up1_q);
      end
    endcase
  end

  assign job_valid_o    = (state_q == S_PUSH) && (mask_q != 4'd0);
  assign job_sum_o      = win;
  assign job_tag_o.row  = ROW_OW'(row_sel);
  assign job_tag_o.col  = COL_OW'(col_sel);
  assign job_tag_o.last = f_end && (pick == 4'b1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= WID_W'(WID_RST);
      height_q <= HGT_W'(HGT_RST);
      row_q    <= '0;
      col_q    <= '0;
      mask_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == stme_pkg::CFG_FRAME_WIDTH) begin
          width_q <= wsat;
        end else begin
          height_q <= hsat;
        end
        row_q <= '0;
        col_q <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            gx_q    <= grad_x_i;
            gy_q    <= grad_y_i;
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          cx_q    <= prod;
          state_q <= S_MULA;
        end
        S_MULA: begin
          ca_q    <= prod;
          state_q <= S_MULB;
        end
        S_MULB: begin
          cb_q    <= prod;
          state_q <= S_SUM;
        end
        S_SUM: begin
          u_q     <= u_d;
          l_q     <= l_d;
          mask_q  <= mask_d;
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (mask_q == 4'd0) begin
            if (r_ge1) begin
              up2_q <= up1_q;
              up1_q <= u_q;
            end
            if (r_last) begin
              lp2_q <= lp1_q;
              lp1_q <= l_q;
            end
            if (c_edge) begin
              col_q <= '0;
              if (r_last) begin
                row_q <= '0;
              end else begin
                row_q <= row_q + 1'b1;
              end
            end else begin
              col_q <= col_q + 1'b1;
            end
            state_q <= S_IDLE;
          end else if (job_ready_i) begin
            mask_q <= mask_q & ~pick;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/stme_queue.sv
// ----------------------------------------------------------------------------
// stme_queue
// small register fifo between window front and root back
// ----------------------------------------------------------------------------
module stme_queue #(
  parameter int WIDTH = 104,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (32'(cnt_q) < 32'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/stme_back.sv
// ----------------------------------------------------------------------------
// stme_back
// discriminant, bit-serial integer square root, response and frame peak
// ----------------------------------------------------------------------------
module stme_back #(
  parameter int GRAD_BITS = stme_pkg::GRAD_BITS_DEF,
  parameter int TW        = 2 * GRAD_BITS + 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 job_valid_i,
  output logic                                 job_ready_o,
  input  logic [2:0][TW-1:0]                   job_sum_i,
  input  stme_pkg::stme_tag_t                  job_tag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [stme_pkg::RESP_W-1:0]          response_o,
  output logic [stme_pkg::ROW_OUT_W-1:0]       pixel_row_o,
  output logic [stme_pkg::COL_OUT_W-1:0]       pixel_column_o,
  output logic                                 frame_last_o,
  output logic [stme_pkg::RESP_W-1:0]          frame_peak_o
);

  localparam int RW   = stme_pkg::RESP_W;
  localparam int DW   = 2 * TW + 1;
  localparam int NIT  = (DW + 1) / 2;
  localparam int DD   = 2 * NIT;
  localparam int IT_W = $clog2(NIT);

  typedef enum logic [2:0] {B_IDLE, B_SQ1, B_SQ2, B_ROOT, B_OUT} state_e;

  state_e              state_q;
  logic [2:0][TW-1:0]  sum_q;
  stme_pkg::stme_tag_t tag_q;
  logic [DD-1:0]       disc_q;
  logic [NIT:0]        rem_q;
  logic [NIT-1:0]      root_q;
  logic [IT_W-1:0]     it_q;
  logic [RW-1:0]       peak_q;
  logic                out_valid_q;
  logic [RW-1:0]       resp_q, opeak_q;
  logic [stme_pkg::ROW_OUT_W-1:0] orow_q;
  logic [stme_pkg::COL_OUT_W-1:0] ocol_q;
  logic                olast_q;

  logic signed [TW-1:0]   diff, sxy;
  logic signed [2*TW-1:0] sq1, sq2;
  logic [NIT+2:0]         cand, sub;
  logic [NIT:0]           trace, rdiff;
  logic [RW-1:0]          resp, peak_n;
  logic                   load;

  assign diff = $signed(sum_q[0]) - $signed(sum_q[1]);
  assign sxy  = $signed(sum_q[2]);
  assign sq1  = diff * diff;
  assign sq2  = sxy * sxy;

  // one root bit per cycle, two radicand bits taken from the top
  assign cand = {rem_q, disc_q[DD-1:DD-2]};
  assign sub  = (NIT + 3)'({root_q, 2'b01});

  // trace is never below the root for a real window, clamp anyway
  assign trace  = (NIT + 1)'(sum_q[0]) + (NIT + 1)'(sum_q[1]);
  assign rdiff  = (32'(root_q) > 32'(trace)) ? '0 : trace - (NIT + 1)'(root_q);
  assign resp   = RW'(rdiff);
  assign peak_n = (resp > peak_q) ? resp : peak_q;
  assign load   = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  assign job_ready_o    = (state_q == B_IDLE);
  assign out_valid_o    = out_valid_q;
  assign response_o     = resp_q;
  assign pixel_row_o    = orow_q;
  assign pixel_column_o = ocol_q;
  assign frame_last_o   = olast_q;
  assign frame_peak_o   = opeak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
      it_q        <= '0;
    end else begin
      // a beat taken while the next one loads keeps valid high
      if (out_valid_q && out_ready_i && !load) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        peak_q <= '0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            sum_q   <= job_sum_i;
            tag_q   <= job_tag_i;
            state_q <= B_SQ1;
          end
        end
        B_SQ1: begin
          disc_q  <= DD'($unsigned(sq1));
          state_q <= B_SQ2;
        end
        B_SQ2: begin
          disc_q  <= disc_q + DD'({$unsigned(sq2), 2'b00});
          rem_q   <= '0;
          root_q  <= '0;
          it_q    <= '0;
          state_q <= B_ROOT;
        end
        B_ROOT: begin
          if (cand >= sub) begin
            rem_q  <= (NIT + 1)'(cand - sub);
            root_q <= {root_q[NIT-2:0], 1'b1};
          end else begin
            rem_q  <= (NIT + 1)'(cand);
            root_q <= {root_q[NIT-2:0], 1'b0};
          end
          disc_q <= {disc_q[DD-3:0], 2'b00};
          if (32'(it_q) == NIT - 1) begin
            state_q <= B_OUT;
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        B_OUT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            resp_q      <= resp;
            orow_q      <= tag_q.row;
            ocol_q      <= tag_q.col;
            olast_q     <= tag_q.last;
            opeak_q     <= tag_q.last ? peak_n : '0;
            peak_q      <= tag_q.last ? '0 : peak_n;
            state_q     <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/structure_tensor_min_eigen_response.sv
// ----------------------------------------------------------------------------
// structure_tensor_min_eigen_response
// 3x3 structure tensor corner response: twice the smaller eigenvalue per pixel
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 beat contents
//   cfg       in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//   in        in         in_valid_i / in_ready_o   grad_x_i, grad_y_i
//   out       out        out_valid_o / out_ready_i response, row, column,
//                                                  frame_last, frame_peak
//
// - front finishes one gradient beat before taking the next: line buffer read,
//   products of the new, r-2 and r-1 gradients, column sums, 0 to 4 job pushes
// - back finishes one result before taking the next, paced by the bit-serial
//   square root, one root bit per cycle
// - a four-entry job queue lets the front run ahead of the root unit
// - reset clears frame position, peak and handshakes; line buffers need none
// - out stalls hold the output register and, through the queue, the front
//
module structure_tensor_min_eigen_response #(
  parameter int MAX_WIDTH  = stme_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = stme_pkg::MAX_HEIGHT_DEF,
  parameter int GRAD_BITS  = stme_pkg::GRAD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [stme_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [stme_pkg::CFG_W-1:0]        cfg_wdata_i,
  // gradient beats in raster order
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [GRAD_BITS-1:0]       grad_x_i,
  input  logic signed [GRAD_BITS-1:0]       grad_y_i,
  // response beats
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [stme_pkg::RESP_W-1:0]       response_o,
  output logic [stme_pkg::ROW_OUT_W-1:0]    pixel_row_o,
  output logic [stme_pkg::COL_OUT_W-1:0]    pixel_column_o,
  output logic                              frame_last_o,
  output logic [stme_pkg::RESP_W-1:0]       frame_peak_o
);

  // window sum width: nine squares of a GRAD_BITS value plus a sign bit
  localparam int TW    = 2 * GRAD_BITS + 3;
  localparam int TAG_W = $bits(stme_pkg::stme_tag_t);
  localparam int JOB_W = 3 * TW + TAG_W;

  logic                job_valid, job_ready;
  logic [2:0][TW-1:0]  job_sum;
  stme_pkg::stme_tag_t job_tag;

  logic                q_valid, q_ready;
  logic [JOB_W-1:0]    q_data;
  logic [2:0][TW-1:0]  q_sum;
  stme_pkg::stme_tag_t q_tag;

  // window front: line buffers, products and column sums
  stme_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRAD_BITS  (GRAD_BITS),
    .TW         (TW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .grad_x_i    (grad_x_i),
    .grad_y_i    (grad_y_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_sum_o   (job_sum),
    .job_tag_o   (job_tag)
  );

  // jobs wait here for the root unit
  stme_queue #(
    .WIDTH (JOB_W),
    .DEPTH (4)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  ({job_tag, job_sum}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_sum = q_data[3*TW-1:0];
  assign q_tag = q_data[JOB_W-1:3*TW];

  // root back: discriminant, square root, response and peak
  stme_back #(
    .GRAD_BITS (GRAD_BITS),
    .TW        (TW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .job_valid_i    (q_valid),
    .job_ready_o    (q_ready),
    .job_sum_i      (q_sum),
    .job_tag_i      (q_tag),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .response_o     (response_o),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .frame_last_o   (frame_last_o),
    .frame_peak_o   (frame_peak_o)
  );

endmodule

### tb/sv/stme_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stme_response_checker
// watches the config, gradient and response channels of the corner response
// block, predicts every response beat and compares it field by field
// ----------------------------------------------------------------------------
module stme_response_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [stme_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [stme_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [stme_pkg::GRAD_BITS_DEF-1:0] grad_x_i,
  input  logic signed [stme_pkg::GRAD_BITS_DEF-1:0] grad_y_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic [stme_pkg::RESP_W-1:0]            response_i,
  input  logic [stme_pkg::ROW_OUT_W-1:0]         pixel_row_i,
  input  logic [stme_pkg::COL_OUT_W-1:0]         pixel_column_i,
  input  logic                                   frame_last_i,
  input  logic [stme_pkg::RESP_W-1:0]            frame_peak_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  localparam int LINE   = stme_pkg::MAX_WIDTH_DEF;
  localparam int GB     = stme_pkg::GRAD_BITS_DEF;
  localparam int RESP_W = stme_pkg::RESP_W;
  localparam int ROW_W  = stme_pkg::ROW_OUT_W;
  localparam int COL_W  = stme_pkg::COL_OUT_W;

  typedef struct {
    longint xx;
    longint yy;
    longint xy;
  } tensor_t;

  typedef struct {
    logic [RESP_W-1:0] resp;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
    logic [RESP_W-1:0] peak;
  } corner_beat_t;

  corner_beat_t         corner_q[$];
  logic [2*GB-1:0]      grad_line[2*LINE];
  int unsigned          cur_row, cur_col, width, height;
  logic [RESP_W-1:0]    peak_so_far;
  tensor_t              up1, up2, lo1, lo2;

  function automatic tensor_t grad_products(logic signed [GB-1:0] gx,
                                            logic signed [GB-1:0] gy);
    tensor_t t;
    t.xx = longint'(gx) * longint'(gx);
    t.yy = longint'(gy) * longint'(gy);
    t.xy = longint'(gx) * longint'(gy);
    return t;
  endfunction

  function automatic tensor_t tensor_sum3(tensor_t a, tensor_t b, tensor_t c);
    tensor_t t;
    t.xx = a.xx + b.xx + c.xx;
    t.yy = a.yy + b.yy + c.yy;
    t.xy = a.xy + b.xy + c.xy;
    return t;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned d);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > d) bitv >>= 2;
    while (bitv != 0) begin
      if (d >= res + bitv) begin
        d   = d - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // twice the smaller eigenvalue, trace minus floored root of discriminant
  function automatic logic [RESP_W-1:0] min_eigen2(tensor_t s);
    longint          diff;
    longint unsigned disc, root, trace;
    diff  = s.xx - s.yy;
    disc  = longint'(diff * diff) + 4 * s.xy * s.xy;
    root  = floor_root(disc);
    trace = s.xx + s.yy;
    if (root > trace) return '0;
    return RESP_W'(trace - root);
  endfunction

  task automatic push_corner(tensor_t s, int unsigned row, int unsigned col);
    corner_beat_t b;
    b.resp = min_eigen2(s);
    b.row  = ROW_W'(row);
    b.col  = COL_W'(col);
    b.last = 1'b0;
    b.peak = '0;
    if (b.resp > peak_so_far) peak_so_far = b.resp;
    corner_q.push_back(b);
  endtask

  task automatic restart_frame();
    tensor_t z;
    z = '{0, 0, 0};
    cur_row = 0; cur_col = 0; peak_so_far = '0;
    up1 = z; up2 = z; lo1 = z; lo2 = z;
  endtask

  task automatic take_gradient(logic signed [GB-1:0] gx, logic signed [GB-1:0] gy);
    int unsigned r, c, cur_idx, oth_idx, n;
    tensor_t     cx, ca, cb, u, l;
    r = cur_row; c = cur_col; n = 0;
    cur_idx = (r & 1) * LINE + c;
    oth_idx = ((r + 1) & 1) * LINE + c;
    cx = grad_products(gx, gy);
    // rows older than the current frame are never used, see the row checks below
    ca = grad_products(grad_line[cur_idx][GB-1:0], grad_line[cur_idx][2*GB-1:GB]);
    cb = grad_products(grad_line[oth_idx][GB-1:0], grad_line[oth_idx][2*GB-1:GB]);
    if (r >= 1) begin
      // upper output row, mirrored at the top border on row 1
      u = tensor_sum3(r == 1 ? cx : ca, cb, cx);
      if (c >= 1) begin
        push_corner(tensor_sum3(c == 1 ? u : up2, up1, u), r - 1, c - 1); n++;
        if (c == width - 1) begin
          push_corner(tensor_sum3(up1, u, up1), r - 1, c); n++;
        end
      end
      up2 = up1; up1 = u;
      // last input row also closes the bottom output row
      if (r == height - 1) begin
        l = tensor_sum3(cb, cx, cb);
        if (c >= 1) begin
          push_corner(tensor_sum3(c == 1 ? l : lo2, lo1, l), r, c - 1); n++;
          if (c == width - 1) begin
            push_corner(tensor_sum3(lo1, l, lo1), r, c); n++;
          end
        end
        lo2 = lo1; lo1 = l;
      end
    end
    grad_line[cur_idx] = {gy, gx};
    if (c + 1 >= width) begin
      cur_col = 0;
      if (r + 1 >= height) begin
        if (n > 0) begin
          corner_q[$].last = 1'b1;
          corner_q[$].peak = peak_so_far;
        end
        restart_frame();
      end else begin
        cur_row = r + 1;
      end
    end else begin
      cur_col = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    corner_beat_t want;
    int unsigned  v;
    if (!rst_ni) begin
      width  = stme_pkg::FRAME_WIDTH_RST;
      height = stme_pkg::FRAME_HEIGHT_RST;
      restart_frame();
      corner_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (corner_q.size() == 0) begin
          $display("%0t: unexpected response beat resp=%0d row=%0d col=%0d", $time,
                   response_i, pixel_row_i, pixel_column_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = corner_q.pop_front();
          if (want.resp !== response_i || want.row !== pixel_row_i ||
              want.col !== pixel_column_i || want.last !== frame_last_i ||
              want.peak !== frame_peak_i) begin
            $display("%0t: mismatch exp resp=%0d row=%0d col=%0d last=%0b peak=%0d",
                     $time, want.resp, want.row, want.col, want.last, want.peak);
            $display("%0t:          got resp=%0d row=%0d col=%0d last=%0b peak=%0d",
                     $time, response_i, pixel_row_i, pixel_column_i, frame_last_i,
                     frame_peak_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == stme_pkg::CFG_FRAME_WIDTH) begin
          v = cfg_wdata_i[stme_pkg::CFG_WID_W-1:0];
          width = v < 2 ? 2 : (v > LINE ? LINE : v);
        end else begin
          v = cfg_wdata_i;
          height = v < 2 ? 2 :
                   (v > stme_pkg::MAX_HEIGHT_DEF ? stme_pkg::MAX_HEIGHT_DEF : v);
        end
        restart_frame();
      end
      if (in_valid_i && in_ready_i) take_gradient(grad_x_i, grad_y_i);
      pending_o <= corner_q.size();
    end
  end

endmodule

### tb/sv/tb_structure_tensor_min_eigen_response.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_structure_tensor_min_eigen_response
// streams gradient frames of many sizes through the corner response block,
// with random gaps and output stalls, while the checker predicts each beat
// ----------------------------------------------------------------------------
module tb_structure_tensor_min_eigen_response;

  localparam int GB        = stme_pkg::GRAD_BITS_DEF;
  localparam int CYC_LIMIT = 1_000_000;
  // front plus root unit for a full job queue, with lots of slack
  localparam int SETTLE    = 200;

  // value shapes for gradient content
  typedef enum int { GRAD_FULL, GRAD_SMALL, GRAD_EDGE } grad_shape_e;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [stme_pkg::CFG_ADDR_W-1:0]      cfg_addr_i = stme_pkg::CFG_FRAME_WIDTH;
  logic [stme_pkg::CFG_W-1:0]           cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic signed [GB-1:0]                 grad_x_i = '0;
  logic signed [GB-1:0]                 grad_y_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [stme_pkg::RESP_W-1:0]          response_o;
  logic [stme_pkg::ROW_OUT_W-1:0]       pixel_row_o;
  logic [stme_pkg::COL_OUT_W-1:0]       pixel_column_o;
  logic                                 frame_last_o;
  logic [stme_pkg::RESP_W-1:0]          frame_peak_o;

  int fail_count, pending, cycles;
  int stall_left, calm_left;
  bit gapless;   // sender runs without gaps for a stretch

  always #6 clk_i = ~clk_i;

  structure_tensor_min_eigen_response dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .grad_x_i, .grad_y_i,
    .out_valid_o, .out_ready_i, .response_o, .pixel_row_o, .pixel_column_o,
    .frame_last_o, .frame_peak_o
  );

  stme_response_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .grad_x_i, .grad_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .response_i(response_o),
    .pixel_row_i(pixel_row_o), .pixel_column_i(pixel_column_o),
    .frame_last_i(frame_last_o), .frame_peak_i(frame_peak_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: mostly ready, short and long stalls, and calm stretches
  always @(posedge clk_i) begin
    int pick;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_ready_i <= 1'b1;
      calm_left   <= calm_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        calm_left   <= $urandom_range(20, 120);
        out_ready_i <= 1'b1;
      end else if (pick < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left  <= (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // one register write, only with the block idle
  task automatic write_reg(logic [stme_pkg::CFG_ADDR_W-1:0] idx, int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= stme_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one gradient beat, then a random gap
  task automatic send_grad(logic signed [GB-1:0] gx, logic signed [GB-1:0] gy);
    int gap, pick;
    in_valid_i <= 1'b1;
    grad_x_i   <= gx;
    grad_y_i   <= gy;
    do @(posedge clk_i); while (!in_ready_o);
    pick = $urandom_range(0, 99);
    if (gapless || pick < 60) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [GB-1:0] pick_grad(grad_shape_e shape);
    case (shape)
      GRAD_SMALL: return GB'($signed($urandom_range(0, 31)) - 16);
      GRAD_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return -12'sd2048;
          1:       return 12'sd2047;
          2:       return '0;
          default: return GB'($urandom);
        endcase
      end
      default:    return GB'($urandom);
    endcase
  endfunction

  task automatic send_pixels(int count, grad_shape_e shape);
    for (int i = 0; i < count; i++) send_grad(pick_grad(shape), pick_grad(shape));
  endtask

  // wait until every predicted beat has come out and the front is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    // let the pending count cover the last accepted beat
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic frame_size(int unsigned w, int unsigned h);
    write_reg(stme_pkg::CFG_FRAME_WIDTH, w);
    write_reg(stme_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int w, h, sent, shape;
    cycles = 0; stall_left = 0; calm_left = 0; gapless = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame, gradient extremes in every corner
    frame_size(2, 2);
    send_grad(-12'sd2048, -12'sd2048);
    send_grad(12'sd2047, 12'sd2047);
    send_grad(12'sd2047, -12'sd2048);
    send_grad(-12'sd2048, 12'sd2047);
    settle();

    // 3x3 with a lone corner-like spike and a flat region
    frame_size(3, 3);
    send_grad(0, 0);    send_grad(0, 0);     send_grad(0, 0);
    send_grad(0, 0);    send_grad(12'sd2047, -12'sd2048); send_grad(0, 0);
    send_grad(12'sd5, 12'sd5); send_grad(-12'sd1, 12'sd1); send_grad(0, 12'sd2047);
    settle();

    // out of range sizes saturate: width 0 -> 2, height all ones -> max
    write_reg(stme_pkg::CFG_FRAME_WIDTH, 0);
    write_reg(stme_pkg::CFG_FRAME_HEIGHT, 13'h1fff);
    send_pixels(8, GRAD_EDGE);
    settle();

    // restart mid frame: first row alone gives nothing, then resize
    frame_size(4, 3);
    send_pixels(6, GRAD_FULL);
    settle();
    write_reg(stme_pkg::CFG_FRAME_HEIGHT, 1);
    send_pixels(8, GRAD_SMALL);
    settle();

    // random well-formed frames of small size, occasionally cut short
    sent = 0;
    while (sent < 50) begin
      w = $urandom_range(2, 6);
      h = $urandom_range(2, 5);
      shape = $urandom_range(0, 2);
      gapless = ($urandom_range(0, 3) == 0);
      frame_size(w, h);
      if ($urandom_range(0, 7) == 0) begin
        send_pixels($urandom_range(1, w * h - 1), grad_shape_e'(shape));
        sent += 1;
      end else begin
        send_pixels(w * h, grad_shape_e'(shape));
        sent += w * h;
      end
      settle();
    end
    gapless = 1'b0;

    // widest line, width register written above its range, opening pixels only
    write_reg(stme_pkg::CFG_FRAME_WIDTH, 13'h1fff);
    write_reg(stme_pkg::CFG_FRAME_HEIGHT, 2);
    send_pixels(8, GRAD_FULL);
    settle();

    // tallest frame, only its opening rows, then back to small sizes
    frame_size(2, stme_pkg::MAX_HEIGHT_DEF);
    send_pixels(12, GRAD_FULL);
    settle();
    frame_size(3, 2);
    send_pixels(6, GRAD_SMALL);
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### structure_tensor_min_eigen_response.f
rtl/stme_pkg.sv
rtl/stme_ram.sv
rtl/stme_front.sv
rtl/stme_queue.sv
rtl/stme_back.sv
rtl/structure_tensor_min_eigen_response.sv
tb/sv/stme_response_checker.sv
tb/sv/tb_structure_tensor_min_eigen_response.sv
